FILE: hdl/dws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg
// Shared constants, codes and controller/datapath interface types for the
// double-ended queue with search.
// ----------------------------------------------------------------------------
package dws_pkg;

    // Sizing
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int STS_W  = 2;
    localparam int OCC_W  = 5;

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;

    // Status codes
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic exec_op;      // run a push, pop or no-op and post its result
        logic srch_start;   // latch the key and rewind the scan
        logic srch_run;     // scan one entry per cycle
        logic srch_finish;  // post the search result
    } dws_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic srch_hit;     // current compare matched
        logic srch_end;     // every occupied entry compared, none pending
    } dws_sts_t;

    // Ring position: (base + off) modulo DEPTH, with base < DEPTH, off <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: hdl/deque_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search
// Push and pop at either end, and unused codes: result beat in the cycle after
//   start, busy stays low, so one command per cycle.
// Search: the key is latched and the scan rewound, then one entry per cycle
//   is read through the single RAM read port and compared; the result beat
//   follows a hit or the end of the occupied entries; busy held meanwhile.
// Reset clears head pointer and count (queue empty); the store is not cleared.
// ----------------------------------------------------------------------------
module deque_with_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dws_pkg::ACT_W-1:0]           action,
    input  logic signed [dws_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic [dws_pkg::STS_W-1:0]           status,
    output logic                                found,
    output logic [dws_pkg::OCC_W-1:0]           occupancy
);

    dws_pkg::dws_cmd_t cmd;
    dws_pkg::dws_sts_t sts;

    dws_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    dws_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (action),
        .value     (value),
        .done      (done),
        .status    (status),
        .found     (found),
        .occupancy (occupancy)
    );

endmodule

FILE: hdl/dws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/dws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_datapath
// Ring store, head pointer, occupancy count, search scan and result registers.
// ----------------------------------------------------------------------------
module dws_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dws_pkg::dws_cmd_t                   cmd,
    output dws_pkg::dws_sts_t                   sts,
    input  logic [dws_pkg::ACT_W-1:0]           action,
    input  logic signed [dws_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic [dws_pkg::STS_W-1:0]           status,
    output logic                                found,
    output logic [dws_pkg::OCC_W-1:0]           occupancy
);

    logic [dws_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [dws_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dws_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic [dws_pkg::DATA_W-1:0] key_reg, key_next;
    logic                       done_reg, done_next;
    logic [dws_pkg::STS_W-1:0]  status_reg, status_next;
    logic                       found_reg, found_next;
    logic [dws_pkg::OCC_W-1:0]  occ_reg, occ_next;

    logic [dws_pkg::ADDR_W-1:0] head_prev, head_succ, tail_addr, raddr, waddr;
    logic [dws_pkg::DATA_W-1:0] rdata;
    logic [dws_pkg::STS_W-1:0]  exec_status;
    logic                       is_full, is_empty, we, hit, srch_issue;

    // Ring neighbors of the head and the slot after the tail
    assign head_prev = (head_reg == '0) ? dws_pkg::LAST_IDX : head_reg - 1'b1;
    assign head_succ = (head_reg == dws_pkg::LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_addr = dws_pkg::ring_add(head_reg, count_reg);
    assign is_full   = (count_reg == dws_pkg::FULL_CNT);
    assign is_empty  = (count_reg == '0);

    // Decode push and pop actions
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        we          = 1'b0;
        waddr       = tail_addr;
        exec_status = dws_pkg::ST_OK;
        if (cmd.exec_op)
        begin
            case (action)
                dws_pkg::ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        exec_status = dws_pkg::ST_FULL;
                    end
                    else
                    begin
                        head_next  = head_prev;
                        waddr      = head_prev;
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dws_pkg::ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        exec_status = dws_pkg::ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dws_pkg::ACT_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        exec_status = dws_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        // keep the head when the last entry leaves
                        if (count_reg != dws_pkg::CNT_W'(1))
                        begin
                            head_next = head_succ;
                        end
                    end
                end
                dws_pkg::ACT_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        exec_status = dws_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    exec_status = dws_pkg::ST_OK;
                end
            endcase
        end
    end

    // Search scan: issue one read per cycle, compare the previous read
    assign hit        = rd_pend_reg && (rdata == key_reg);
    assign srch_issue = cmd.srch_run && (idx_reg < count_reg) && !hit;
    assign raddr      = dws_pkg::ring_add(head_reg, idx_reg);

    assign sts.srch_hit = hit;
    assign sts.srch_end = !rd_pend_reg && (idx_reg >= count_reg);

    always_comb
    begin
        key_next     = key_reg;
        idx_next     = idx_reg;
        rd_pend_next = srch_issue;
        if (cmd.srch_start)
        begin
            key_next = value;
            idx_next = '0;
        end
        else if (srch_issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Result beat
    always_comb
    begin
        done_next   = cmd.exec_op | cmd.srch_finish;
        status_next = status_reg;
        found_next  = found_reg;
        occ_next    = occ_reg;
        if (cmd.exec_op)
        begin
            status_next = exec_status;
            found_next  = 1'b0;
            occ_next    = dws_pkg::OCC_W'(count_next);
        end
        else if (cmd.srch_finish)
        begin
            status_next = dws_pkg::ST_OK;
            found_next  = hit;
            occ_next    = dws_pkg::OCC_W'(count_reg);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        occ_reg    <= occ_next;
    end

    dws_ram #(
        .WIDTH (dws_pkg::DATA_W),
        .DEPTH (dws_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value),
        .re    (srch_issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign occupancy = occ_reg;

endmodule

FILE: hdl/dws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_ctrl
// Command sequencer: runs pushes and pops at once and walks searches.
// ----------------------------------------------------------------------------
module dws_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dws_pkg::ACT_W-1:0]   action,
    input  dws_pkg::dws_sts_t           sts,
    output dws_pkg::dws_cmd_t           cmd,
    output logic                        busy
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == dws_pkg::ACT_SEARCH)
                    begin
                        cmd.srch_start = 1'b1;
                        state_next     = S_SEARCH;
                        busy_next      = 1'b1;
                    end
                    else
                    begin
                        cmd.exec_op = 1'b1;
                    end
                end
            end
            S_SEARCH:
            begin
                cmd.srch_run = 1'b1;
                if (sts.srch_hit || sts.srch_end)
                begin
                    cmd.srch_finish = 1'b1;
                    state_next      = S_IDLE;
                    busy_next       = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // Hold state and busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: hdl/dws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_checker
// Port-level checks on command completion and result consistency.
// ----------------------------------------------------------------------------
module dws_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [dws_pkg::ACT_W-1:0]           action,
    input logic                                done,
    input logic [dws_pkg::STS_W-1:0]           status,
    input logic                                found,
    input logic [dws_pkg::OCC_W-1:0]           occupancy
);

    logic accept;
    assign accept = start && !busy;

    // Non-search beat completes in the next cycle
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action != dws_pkg::ACT_SEARCH) |=> done && !busy)
        else $error("push/pop did not complete in one cycle");

    // Search holds off new commands
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == dws_pkg::ACT_SEARCH) |=> busy && !done)
        else $error("search did not raise busy");

    // Busy drops only with the search result
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result beat");

    // Full report carries a full count
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == dws_pkg::ST_FULL)
            |-> (occupancy == dws_pkg::OCC_W'(dws_pkg::DEPTH)) && !found)
        else $error("full status with wrong occupancy");

    // Empty report carries a zero count
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == dws_pkg::ST_EMPTY) |-> (occupancy == '0) && !found)
        else $error("empty status with nonzero occupancy");

endmodule

bind deque_with_search dws_checker u_dws_checker (.*);
